/* hdl/tam_pkg.sv */
// Shared types, codes and constants for the threshold alarm setpoint menu block.
package tam_pkg;

   // Limit bounds and reset values
   localparam logic [6:0] LIMIT_MAX        = 7'd99;
   localparam logic [6:0] LIMIT_MIN        = 7'd1;
   localparam logic [6:0] TEMP_HI_RESET    = 7'd35;
   localparam logic [6:0] TEMP_LO_RESET    = 7'd10;
   localparam logic [6:0] HUM_HI_RESET     = 7'd80;
   localparam logic [6:0] HUM_LO_RESET     = 7'd10;

   // Request kinds
   typedef enum logic {
      REQ_KEY     = 1'b0,
      REQ_READING = 1'b1
   } tam_req_type;

   // Key codes
   typedef enum logic [1:0] {
      KEY_NONE  = 2'd0,
      KEY_MENU  = 2'd1,
      KEY_PLUS  = 2'd2,
      KEY_MINUS = 2'd3
   } tam_key_type;

   // Menu states
   typedef enum logic [2:0] {
      MENU_NORMAL  = 3'd0,
      MENU_TEMP_HI = 3'd1,
      MENU_TEMP_LO = 3'd2,
      MENU_HUM_HI  = 3'd3,
      MENU_HUM_LO  = 3'd4
   } tam_menu_type;

   // Relay bit positions
   localparam int RELAY_TEMP_HI = 0;
   localparam int RELAY_TEMP_LO = 1;
   localparam int RELAY_HUM_HI  = 2;
   localparam int RELAY_HUM_LO  = 3;

   // Controller state, also the result word
   typedef struct packed {
      tam_menu_type menu;
      logic [6:0]   temp_hi;
      logic [6:0]   temp_lo;
      logic [6:0]   hum_hi;
      logic [6:0]   hum_lo;
      logic         alarm_en;
      logic         buzzer;
      logic [3:0]   relay;
   } tam_state_type;

   localparam tam_state_type STATE_RESET = '{
      menu:     MENU_NORMAL,
      temp_hi:  TEMP_HI_RESET,
      temp_lo:  TEMP_LO_RESET,
      hum_hi:   HUM_HI_RESET,
      hum_lo:   HUM_LO_RESET,
      alarm_en: 1'b1,
      buzzer:   1'b0,
      relay:    4'd0
   };

endpackage

/* hdl/threshold_alarm_setpoint_menu_core.sv */
// Top level of the threshold alarm setpoint menu controller.
//
// Usage: each request transfer on the req_ channel is either a key event
// (req_type 0, req_key_code) or a sensor reading (req_type 1,
// req_temperature, req_humidity). Every request yields exactly one
// response transfer on the rsp_ channel carrying the four relays, the
// buzzer, the menu state and the four current limits after that event.
// A transfer happens at a rising clock edge with valid high and stall low.
// A request transfer is captured in the request register; when it is processed,
// its result is written into the state/result register, which raises rsp_valid
// and drives the response.
// Throughput: one request per cycle while the receiver does not stall; the
// state register that also holds the result is the only loop.
// Reset (synchronous, active high) restores the limits to 35/10/80/10,
// normal menu, alarm unmuted, buzzer and relays off, and empties both
// registers. When the receiver stalls, the response is held and at most one
// more request is taken into the request register; after that req_stall rises.
module threshold_alarm_setpoint_menu_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_type,
   input  logic [1:0] req_key_code,
   input  logic [7:0] req_temperature,
   input  logic [7:0] req_humidity,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_temp_high_relay,
   output logic       rsp_temp_low_relay,
   output logic       rsp_hum_high_relay,
   output logic       rsp_hum_low_relay,
   output logic       rsp_buzzer,
   output logic [2:0] rsp_menu_state,
   output logic [6:0] rsp_temp_upper_limit,
   output logic [6:0] rsp_temp_lower_limit,
   output logic [6:0] rsp_hum_upper_limit,
   output logic [6:0] rsp_hum_lower_limit
);

   logic                   in_valid_ff;
   logic                   in_valid_in;
   logic                   in_type_ff;
   logic [1:0]             in_key_ff;
   logic [7:0]             in_temp_ff;
   logic [7:0]             in_hum_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   tam_pkg::tam_state_type state_ff;
   tam_pkg::tam_state_type state_in;
   tam_pkg::tam_state_type key_state;
   tam_pkg::tam_state_type read_state;
   logic                   req_xfer;
   logic                   advance;

   // Process the held request when the result register is free or drains
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_xfer  = req_valid && !req_stall;

   // Hold the request register until it is processed
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_type_ff <= req_type;
         in_key_ff  <= req_key_code;
         in_temp_ff <= req_temperature;
         in_hum_ff  <= req_humidity;
      end
   end

   tam_key_ctrl u_key_ctrl (
      .cur_state (state_ff),
      .key_code  (in_key_ff),
      .key_state (key_state)
   );

   tam_alarm_eval u_alarm_eval (
      .cur_state   (state_ff),
      .temperature (in_temp_ff),
      .humidity    (in_hum_ff),
      .read_state  (read_state)
   );

   // Select the event path and advance the state, which is also the result
   always_comb begin
      state_in = state_ff;
      if (advance) begin
         state_in = (in_type_ff == tam_pkg::REQ_READING) ? read_state : key_state;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tam_pkg::STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Drive the response from the state register
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_temp_high_relay  = state_ff.relay[tam_pkg::RELAY_TEMP_HI];
   assign rsp_temp_low_relay   = state_ff.relay[tam_pkg::RELAY_TEMP_LO];
   assign rsp_hum_high_relay   = state_ff.relay[tam_pkg::RELAY_HUM_HI];
   assign rsp_hum_low_relay    = state_ff.relay[tam_pkg::RELAY_HUM_LO];
   assign rsp_buzzer           = state_ff.buzzer;
   assign rsp_menu_state       = state_ff.menu;
   assign rsp_temp_upper_limit = state_ff.temp_hi;
   assign rsp_temp_lower_limit = state_ff.temp_lo;
   assign rsp_hum_upper_limit  = state_ff.hum_hi;
   assign rsp_hum_lower_limit  = state_ff.hum_lo;

`ifndef SYNTH
   // State only moves when a request is processed
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("state changed without a processed request");

   // Each limit pair stays ordered and within bounds
   a_limit_order: assert property (@(posedge clock) disable iff (reset)
      state_ff.temp_lo < state_ff.temp_hi && state_ff.hum_lo < state_ff.hum_hi &&
      state_ff.temp_hi <= tam_pkg::LIMIT_MAX && state_ff.hum_hi <= tam_pkg::LIMIT_MAX &&
      state_ff.temp_lo >= tam_pkg::LIMIT_MIN && state_ff.hum_lo >= tam_pkg::LIMIT_MIN)
      else $error("limit pair out of order or out of bounds");

   // A key press silences the buzzer
   a_key_silence: assert property (@(posedge clock) disable iff (reset)
      advance && in_type_ff == tam_pkg::REQ_KEY && in_key_ff != tam_pkg::KEY_NONE
      |=> !state_ff.buzzer)
      else $error("buzzer still on after key press");

   // A quiet reading clears the buzzer and releases the mute
   a_quiet_reading: assert property (@(posedge clock) disable iff (reset)
      advance && in_type_ff == tam_pkg::REQ_READING && read_state.relay == 4'd0
      |=> !state_ff.buzzer && state_ff.alarm_en)
      else $error("quiet reading left buzzer on or alarm muted");

   // A processed request always produces a valid response
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed request without response");
`endif

endmodule

/* hdl/tam_key_ctrl.sv */
// Key event path: menu stepping, limit edits with clamps, mute and buzzer clear.
module tam_key_ctrl (
   input  tam_pkg::tam_state_type cur_state,
   input  logic [1:0]             key_code,
   output tam_pkg::tam_state_type key_state
);

   // Step a high limit up (clamp to max) or down (keep above its low)
   function automatic logic [6:0] move_high(input logic [6:0] hi, input logic up,
                                            input logic [6:0] lo);
      logic [7:0] inc;
      logic [7:0] dec;
      logic [7:0] res;
      inc = {1'b0, hi} + 8'd1;
      dec = (hi == 7'd0) ? 8'd0 : {1'b0, hi} - 8'd1;
      if (up) begin
         res = (inc > {1'b0, tam_pkg::LIMIT_MAX}) ? {1'b0, tam_pkg::LIMIT_MAX} : inc;
      end else begin
         res = (dec <= {1'b0, lo}) ? {1'b0, lo} + 8'd1 : dec;
      end
      return res[6:0];
   endfunction

   // Step a low limit up (keep below its high) or down (clamp to min)
   function automatic logic [6:0] move_low(input logic [6:0] lo, input logic up,
                                           input logic [6:0] hi);
      logic [7:0] inc;
      logic [7:0] dec;
      logic [7:0] res;
      inc = {1'b0, lo} + 8'd1;
      dec = (lo == 7'd0) ? 8'd0 : {1'b0, lo} - 8'd1;
      if (up) begin
         if (inc >= {1'b0, hi}) begin
            res = (hi == 7'd0) ? 8'd0 : {1'b0, hi} - 8'd1;
         end else begin
            res = inc;
         end
      end else begin
         res = (dec <= {1'b0, tam_pkg::LIMIT_MIN}) ? {1'b0, tam_pkg::LIMIT_MIN} : dec;
      end
      return res[6:0];
   endfunction

   logic up;

   assign up = (key_code == tam_pkg::KEY_PLUS);

   // Decode the key against the current menu
   always_comb begin
      key_state = cur_state;
      if (key_code != tam_pkg::KEY_NONE) begin
         key_state.buzzer = 1'b0;
      end
      if (key_code == tam_pkg::KEY_MENU) begin
         key_state.menu = (cur_state.menu == tam_pkg::MENU_HUM_LO) ? tam_pkg::MENU_NORMAL :
                          tam_pkg::tam_menu_type'(cur_state.menu + 3'd1);
      end else if (key_code == tam_pkg::KEY_PLUS || key_code == tam_pkg::KEY_MINUS) begin
         case (cur_state.menu)
            tam_pkg::MENU_TEMP_HI: begin
               key_state.temp_hi = move_high(cur_state.temp_hi, up, cur_state.temp_lo);
            end
            tam_pkg::MENU_TEMP_LO: begin
               key_state.temp_lo = move_low(cur_state.temp_lo, up, cur_state.temp_hi);
            end
            tam_pkg::MENU_HUM_HI: begin
               key_state.hum_hi = move_high(cur_state.hum_hi, up, cur_state.hum_lo);
            end
            tam_pkg::MENU_HUM_LO: begin
               key_state.hum_lo = move_low(cur_state.hum_lo, up, cur_state.hum_hi);
            end
            default: begin
               // minus in normal display mutes the alarm
               if (cur_state.menu == tam_pkg::MENU_NORMAL && !up) begin
                  key_state.alarm_en = 1'b0;
               end
            end
         endcase
      end
   end

endmodule

/* hdl/tam_alarm_eval.sv */
// Reading event path: relay compares against the limits and buzzer toggling.
module tam_alarm_eval (
   input  tam_pkg::tam_state_type cur_state,
   input  logic [7:0]             temperature,
   input  logic [7:0]             humidity,
   output tam_pkg::tam_state_type read_state
);

   logic [3:0] relay;

   // Compare each reading with its two limits
   always_comb begin
      relay = 4'd0;
      relay[tam_pkg::RELAY_TEMP_HI] = (temperature >= {1'b0, cur_state.temp_hi});
      relay[tam_pkg::RELAY_TEMP_LO] = (temperature <= {1'b0, cur_state.temp_lo});
      relay[tam_pkg::RELAY_HUM_HI]  = (humidity >= {1'b0, cur_state.hum_hi});
      relay[tam_pkg::RELAY_HUM_LO]  = (humidity <= {1'b0, cur_state.hum_lo});
   end

   // Toggle the buzzer while alarmed and unmuted; clear and unmute when quiet
   always_comb begin
      read_state       = cur_state;
      read_state.relay = relay;
      if (relay != 4'd0) begin
         if (cur_state.alarm_en) begin
            read_state.buzzer = ~cur_state.buzzer;
         end
      end else begin
         read_state.buzzer   = 1'b0;
         read_state.alarm_en = 1'b1;
      end
   end

endmodule

/* tb/alarm_response_check.sv */
// Response checker for the threshold alarm setpoint menu core: predicts and compares each transfer.
module alarm_response_check (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic       req_type,
   input  logic [1:0] req_key_code,
   input  logic [7:0] req_temperature,
   input  logic [7:0] req_humidity,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic       rsp_temp_high_relay,
   input  logic       rsp_temp_low_relay,
   input  logic       rsp_hum_high_relay,
   input  logic       rsp_hum_low_relay,
   input  logic       rsp_buzzer,
   input  logic [2:0] rsp_menu_state,
   input  logic [6:0] rsp_temp_upper_limit,
   input  logic [6:0] rsp_temp_lower_limit,
   input  logic [6:0] rsp_hum_upper_limit,
   input  logic [6:0] rsp_hum_lower_limit,
   output int         errors,
   output int         awaiting,
   output int         responses
);

   typedef struct packed {
      logic [3:0]            relay;
      logic                  buzzer;
      tam_pkg::tam_menu_type menu;
      logic [6:0]            temp_hi;
      logic [6:0]            temp_lo;
      logic [6:0]            hum_hi;
      logic [6:0]            hum_lo;
   } alarm_status_type;

   // Predicted controller state
   tam_pkg::tam_menu_type menu_sel;
   logic [6:0]            temp_hi;
   logic [6:0]            temp_lo;
   logic [6:0]            hum_hi;
   logic [6:0]            hum_lo;
   logic                  alarm_armed;
   logic                  buzz;
   logic [3:0]            relays;

   alarm_status_type expected_status[$];
   int               fail_cnt = 0;
   int               seen = 0;

   // Move an upper limit one step, keeping it at most the maximum and above its low
   function automatic logic [6:0] step_high(input logic [6:0] hi, input logic up,
                                            input logic [6:0] lo);
      int v;
      if (up) begin
         v = int'(hi) + 1;
         if (v > int'(tam_pkg::LIMIT_MAX)) v = int'(tam_pkg::LIMIT_MAX);
      end else begin
         v = (hi == 7'd0) ? 0 : int'(hi) - 1;
         if (v <= int'(lo)) v = int'(lo) + 1;
      end
      return v[6:0];
   endfunction

   // Move a lower limit one step, keeping it below its high and at least the minimum
   function automatic logic [6:0] step_low(input logic [6:0] lo, input logic up,
                                           input logic [6:0] hi);
      int v;
      if (up) begin
         v = int'(lo) + 1;
         if (v >= int'(hi)) v = (hi == 7'd0) ? 0 : int'(hi) - 1;
      end else begin
         v = (lo == 7'd0) ? 0 : int'(lo) - 1;
         if (v <= int'(tam_pkg::LIMIT_MIN)) v = int'(tam_pkg::LIMIT_MIN);
      end
      return v[6:0];
   endfunction

   // Advance the predicted state by one event and queue the status it produces
   task automatic apply_event(input logic kind, input logic [1:0] key,
                              input logic [7:0] temp, input logic [7:0] hum);
      logic up;
      up = (key == tam_pkg::KEY_PLUS);
      if (kind == tam_pkg::REQ_KEY) begin
         if (key != tam_pkg::KEY_NONE) begin
            buzz = 1'b0;
            if (key == tam_pkg::KEY_MENU) begin
               menu_sel = (menu_sel == tam_pkg::MENU_HUM_LO) ? tam_pkg::MENU_NORMAL
                                                             : tam_pkg::tam_menu_type'(menu_sel + 1);
            end else begin
               case (menu_sel)
                  tam_pkg::MENU_TEMP_HI: temp_hi = step_high(temp_hi, up, temp_lo);
                  tam_pkg::MENU_TEMP_LO: temp_lo = step_low(temp_lo, up, temp_hi);
                  tam_pkg::MENU_HUM_HI:  hum_hi = step_high(hum_hi, up, hum_lo);
                  tam_pkg::MENU_HUM_LO:  hum_lo = step_low(hum_lo, up, hum_hi);
                  // minus on the normal display mutes the alarm
                  default:               if (!up) alarm_armed = 1'b0;
               endcase
            end
         end
      end else begin
         relays = '0;
         relays[tam_pkg::RELAY_TEMP_HI] = (temp >= {1'b0, temp_hi});
         relays[tam_pkg::RELAY_TEMP_LO] = (temp <= {1'b0, temp_lo});
         relays[tam_pkg::RELAY_HUM_HI]  = (hum >= {1'b0, hum_hi});
         relays[tam_pkg::RELAY_HUM_LO]  = (hum <= {1'b0, hum_lo});
         if (relays != '0) begin
            if (alarm_armed) buzz = ~buzz;
         end else begin
            // all clear: silence and unmute
            buzz = 1'b0;
            alarm_armed = 1'b1;
         end
      end
      expected_status.push_back('{relay: relays, buzzer: buzz, menu: menu_sel,
                                  temp_hi: temp_hi, temp_lo: temp_lo,
                                  hum_hi: hum_hi, hum_lo: hum_lo});
   endtask

   task automatic compare_field(input string what, input int want, input int got);
      if (want != got) begin
         fail_cnt++;
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      end
   endtask

   task automatic compare_status(input alarm_status_type want, input alarm_status_type got);
      compare_field("temp_high_relay", int'(want.relay[tam_pkg::RELAY_TEMP_HI]),
                    int'(got.relay[tam_pkg::RELAY_TEMP_HI]));
      compare_field("temp_low_relay", int'(want.relay[tam_pkg::RELAY_TEMP_LO]),
                    int'(got.relay[tam_pkg::RELAY_TEMP_LO]));
      compare_field("hum_high_relay", int'(want.relay[tam_pkg::RELAY_HUM_HI]),
                    int'(got.relay[tam_pkg::RELAY_HUM_HI]));
      compare_field("hum_low_relay", int'(want.relay[tam_pkg::RELAY_HUM_LO]),
                    int'(got.relay[tam_pkg::RELAY_HUM_LO]));
      compare_field("buzzer", int'(want.buzzer), int'(got.buzzer));
      compare_field("menu_state", int'(want.menu), int'(got.menu));
      compare_field("temp_upper_limit", int'(want.temp_hi), int'(got.temp_hi));
      compare_field("temp_lower_limit", int'(want.temp_lo), int'(got.temp_lo));
      compare_field("hum_upper_limit", int'(want.hum_hi), int'(got.hum_hi));
      compare_field("hum_lower_limit", int'(want.hum_lo), int'(got.hum_lo));
   endtask

   // Watch both channels: predict on each request transfer, compare on each response transfer
   always @(posedge clock) begin
      alarm_status_type got;
      if (reset) begin
         menu_sel    = tam_pkg::MENU_NORMAL;
         temp_hi     = tam_pkg::TEMP_HI_RESET;
         temp_lo     = tam_pkg::TEMP_LO_RESET;
         hum_hi      = tam_pkg::HUM_HI_RESET;
         hum_lo      = tam_pkg::HUM_LO_RESET;
         alarm_armed = 1'b1;
         buzz        = 1'b0;
         relays      = '0;
         expected_status.delete();
      end else begin
         if (req_valid && !req_stall)
            apply_event(req_type, req_key_code, req_temperature, req_humidity);
         if (rsp_valid && !rsp_stall) begin
            got.relay[tam_pkg::RELAY_TEMP_HI] = rsp_temp_high_relay;
            got.relay[tam_pkg::RELAY_TEMP_LO] = rsp_temp_low_relay;
            got.relay[tam_pkg::RELAY_HUM_HI]  = rsp_hum_high_relay;
            got.relay[tam_pkg::RELAY_HUM_LO]  = rsp_hum_low_relay;
            got.buzzer  = rsp_buzzer;
            got.menu    = tam_pkg::tam_menu_type'(rsp_menu_state);
            got.temp_hi = rsp_temp_upper_limit;
            got.temp_lo = rsp_temp_lower_limit;
            got.hum_hi  = rsp_hum_upper_limit;
            got.hum_lo  = rsp_hum_lower_limit;
            seen++;
            if (expected_status.size() == 0) begin
               fail_cnt++;
               $display("%0t: unexpected response: expected none, actual relays %b menu %0d",
                        $time, got.relay, got.menu);
            end else begin
               compare_status(expected_status.pop_front(), got);
            end
         end
      end
      errors    <= fail_cnt;
      awaiting  <= expected_status.size();
      responses <= seen;
   end

endmodule

/* tb/testbench.sv */
// Testbench top for the threshold alarm setpoint menu core: stimulus, stalls and verdict.
module testbench;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_type = tam_pkg::REQ_KEY;
   logic [1:0] req_key_code = tam_pkg::KEY_NONE;
   logic [7:0] req_temperature = 8'd0;
   logic [7:0] req_humidity = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_temp_high_relay;
   logic       rsp_temp_low_relay;
   logic       rsp_hum_high_relay;
   logic       rsp_hum_low_relay;
   logic       rsp_buzzer;
   logic [2:0] rsp_menu_state;
   logic [6:0] rsp_temp_upper_limit;
   logic [6:0] rsp_temp_lower_limit;
   logic [6:0] rsp_hum_upper_limit;
   logic [6:0] rsp_hum_lower_limit;

   int fail_count;
   int outstanding;
   int responses;

   // Sender bookkeeping
   int                    burst_left = 0;
   int                    sent = 0;
   int                    key_presses = 0;
   int                    readings = 0;
   tam_pkg::tam_menu_type menu_pos = tam_pkg::MENU_NORMAL;

   threshold_alarm_setpoint_menu_core u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_type             (req_type),
      .req_key_code         (req_key_code),
      .req_temperature      (req_temperature),
      .req_humidity         (req_humidity),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_temp_high_relay  (rsp_temp_high_relay),
      .rsp_temp_low_relay   (rsp_temp_low_relay),
      .rsp_hum_high_relay   (rsp_hum_high_relay),
      .rsp_hum_low_relay    (rsp_hum_low_relay),
      .rsp_buzzer           (rsp_buzzer),
      .rsp_menu_state       (rsp_menu_state),
      .rsp_temp_upper_limit (rsp_temp_upper_limit),
      .rsp_temp_lower_limit (rsp_temp_lower_limit),
      .rsp_hum_upper_limit  (rsp_hum_upper_limit),
      .rsp_hum_lower_limit  (rsp_hum_lower_limit)
   );

   alarm_response_check u_alarm_check (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_type             (req_type),
      .req_key_code         (req_key_code),
      .req_temperature      (req_temperature),
      .req_humidity         (req_humidity),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_temp_high_relay  (rsp_temp_high_relay),
      .rsp_temp_low_relay   (rsp_temp_low_relay),
      .rsp_hum_high_relay   (rsp_hum_high_relay),
      .rsp_hum_low_relay    (rsp_hum_low_relay),
      .rsp_buzzer           (rsp_buzzer),
      .rsp_menu_state       (rsp_menu_state),
      .rsp_temp_upper_limit (rsp_temp_upper_limit),
      .rsp_temp_lower_limit (rsp_temp_lower_limit),
      .rsp_hum_upper_limit  (rsp_hum_upper_limit),
      .rsp_hum_lower_limit  (rsp_hum_lower_limit),
      .errors               (fail_count),
      .awaiting             (outstanding),
      .responses            (responses)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Stall the response channel in phases: none, random, sparse, long runs
   int stall_mode = 0;
   int phase_left = 0;
   int stall_run = 0;
   always @(posedge clock) begin
      logic hold;
      if (phase_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         phase_left = $urandom_range(10, 200);
      end else begin
         phase_left--;
      end
      case (stall_mode)
         0: hold = 1'b0;
         1: hold = 1'($urandom_range(0, 1));
         2: hold = ($urandom_range(0, 7) == 0);
         default: begin
            if (stall_run > 0) begin
               stall_run--;
               hold = 1'b1;
            end else if ($urandom_range(0, 9) == 0) begin
               stall_run = $urandom_range(5, 20);
               hold = 1'b1;
            end else begin
               hold = 1'b0;
            end
         end
      endcase
      rsp_stall <= hold;
   end

   // Drive one event and hold it until the transfer; insert burst gaps
   task automatic send_event(input tam_pkg::tam_req_type kind, input tam_pkg::tam_key_type key,
                             input logic [7:0] temp, input logic [7:0] hum);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 20);
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_key_code    <= key;
      req_temperature <= temp;
      req_humidity    <= hum;
      do @(posedge clock); while (req_stall);
      sent++;
      if (kind == tam_pkg::REQ_READING) begin
         readings++;
      end else begin
         key_presses++;
         if (key == tam_pkg::KEY_MENU)
            menu_pos = (menu_pos == tam_pkg::MENU_HUM_LO) ? tam_pkg::MENU_NORMAL
                                                          : tam_pkg::tam_menu_type'(menu_pos + 1);
      end
   endtask

   // Favor values around the reset and clamped limits
   function automatic logic [7:0] pick_reading();
      logic [7:0] v;
      case ($urandom_range(0, 4))
         0:       v = 8'($urandom_range(0, 12));
         1:       v = 8'($urandom_range(30, 40));
         2:       v = 8'($urandom_range(75, 101));
         3:       v = 8'($urandom_range(0, 110));
         default: v = 8'($urandom_range(0, 255));
      endcase
      return v;
   endfunction

   function automatic tam_pkg::tam_key_type any_key();
      return tam_pkg::tam_key_type'($urandom_range(0, 3));
   endfunction

   task automatic go_to_menu(input tam_pkg::tam_menu_type target);
      while (menu_pos != target)
         send_event(tam_pkg::REQ_KEY, tam_pkg::KEY_MENU, 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
   endtask

   initial begin
      int                   pick;
      int                   presses;
      logic                 up;
      tam_pkg::tam_key_type key;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: reading extremes, exact limits, mute and release, every menu edit
      send_event(tam_pkg::REQ_READING, tam_pkg::KEY_NONE, 8'd0, 8'd0);
      send_event(tam_pkg::REQ_READING, tam_pkg::KEY_NONE, 8'd255, 8'd255);
      send_event(tam_pkg::REQ_READING, tam_pkg::KEY_NONE, 8'd20, 8'd50);
      send_event(tam_pkg::REQ_KEY, tam_pkg::KEY_NONE, 8'd0, 8'd0);
      send_event(tam_pkg::REQ_READING, tam_pkg::KEY_NONE, 8'd35, 8'd80);
      send_event(tam_pkg::REQ_KEY, tam_pkg::KEY_PLUS, 8'd0, 8'd0);
      send_event(tam_pkg::REQ_KEY, tam_pkg::KEY_MINUS, 8'd0, 8'd0);
      send_event(tam_pkg::REQ_READING, tam_pkg::KEY_NONE, 8'd10, 8'd10);
      send_event(tam_pkg::REQ_READING, tam_pkg::KEY_NONE, 8'd11, 8'd79);
      send_event(tam_pkg::REQ_READING, tam_pkg::KEY_NONE, 8'd36, 8'd9);
      send_event(tam_pkg::REQ_KEY, tam_pkg::KEY_MENU, 8'd0, 8'd0);
      send_event(tam_pkg::REQ_KEY, tam_pkg::KEY_PLUS, 8'd0, 8'd0);
      send_event(tam_pkg::REQ_KEY, tam_pkg::KEY_MINUS, 8'd0, 8'd0);
      send_event(tam_pkg::REQ_KEY, tam_pkg::KEY_MENU, 8'd0, 8'd0);
      send_event(tam_pkg::REQ_KEY, tam_pkg::KEY_PLUS, 8'd0, 8'd0);
      send_event(tam_pkg::REQ_KEY, tam_pkg::KEY_MINUS, 8'd0, 8'd0);
      send_event(tam_pkg::REQ_KEY, tam_pkg::KEY_MENU, 8'd0, 8'd0);
      send_event(tam_pkg::REQ_KEY, tam_pkg::KEY_PLUS, 8'd0, 8'd0);
      send_event(tam_pkg::REQ_KEY, tam_pkg::KEY_MINUS, 8'd0, 8'd0);
      send_event(tam_pkg::REQ_KEY, tam_pkg::KEY_MENU, 8'd0, 8'd0);
      send_event(tam_pkg::REQ_KEY, tam_pkg::KEY_MINUS, 8'd0, 8'd0);
      send_event(tam_pkg::REQ_KEY, tam_pkg::KEY_PLUS, 8'd0, 8'd0);
      send_event(tam_pkg::REQ_KEY, tam_pkg::KEY_MENU, 8'd0, 8'd0);
      send_event(tam_pkg::REQ_READING, tam_pkg::KEY_MINUS, 8'd99, 8'd1);
      send_event(tam_pkg::REQ_KEY, tam_pkg::KEY_NONE, 8'd255, 8'd255);

      // Random: limit edits (some long enough to hit the clamps), readings, mute, noise
      while (sent < 1040) begin
         pick = $urandom_range(0, 19);
         if (pick < 6) begin
            go_to_menu(tam_pkg::tam_menu_type'($urandom_range(1, 4)));
            presses = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 90)
                                                  : $urandom_range(1, 8);
            up = 1'($urandom_range(0, 1));
            repeat (presses) begin
               if ($urandom_range(0, 7) == 0) up = ~up;
               key = up ? tam_pkg::KEY_PLUS : tam_pkg::KEY_MINUS;
               send_event(tam_pkg::REQ_KEY, key, 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)));
            end
            repeat ($urandom_range(0, 3))
               send_event(tam_pkg::REQ_READING, any_key(), pick_reading(), pick_reading());
         end else if (pick < 14) begin
            repeat ($urandom_range(1, 8))
               send_event(tam_pkg::REQ_READING, any_key(), pick_reading(), pick_reading());
         end else if (pick < 17) begin
            go_to_menu(tam_pkg::MENU_NORMAL);
            send_event(tam_pkg::REQ_KEY,
                       tam_pkg::tam_key_type'($urandom_range(0, 1) ? tam_pkg::KEY_MINUS
                                                                   : any_key()),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            repeat ($urandom_range(1, 4))
               send_event(tam_pkg::REQ_READING, any_key(), pick_reading(), pick_reading());
         end else begin
            send_event(tam_pkg::tam_req_type'($urandom_range(0, 1)), any_key(),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         end
      end
      req_valid <= 1'b0;

      // Drain, then allow for the pipeline
      do @(posedge clock); while (outstanding != 0);
      repeat (8) @(posedge clock);

      $display("Covered %0d events: %0d key presses and %0d sensor readings, %0d responses checked.",
               sent, key_presses, readings, responses);
      if (fail_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

   // Timeout guard
   initial begin
      #5000000;
      $display("testbench failed");
      $finish;
   end

endmodule
